### src/b85_pkg.sv
package b85_pkg;

  localparam int unsigned DIGITS     = 5;
  localparam int unsigned DIGIT_MAX  = 84;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned QUOT_W     = 26;

  // x / 85 == (x * RECIP) >> RECIP_SHIFT, exact for every 32-bit x
  localparam logic [31:0] RECIP       = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;

  localparam logic [1:0] ALPHA_Z85     = 2'd0;
  localparam logic [1:0] ALPHA_RFC     = 2'd1;
  localparam logic [1:0] ALPHA_ASCII85 = 2'd2;

  localparam logic [8*85-1:0] Z85_DIGITS =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";
  localparam logic [8*85-1:0] RFC_DIGITS =
    "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz!#$%&()*+-;<=>?@^_`{|}~";

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic take;   // input byte accepted
    logic mul;    // register x * RECIP
    logic dig;    // retire one digit
    logic pop;    // output character taken
  } cmd_t;

  typedef struct packed {
    logic close;      // incoming byte completes the group
    logic dig_done;   // fifth digit being retired
    logic emit_last;  // current character is the last of the group
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [CHAR_W-1:0] d,
                                                   input logic [1:0] sel);
    logic [CHAR_W-1:0] dc;
    logic [CHAR_W-1:0] pos;
    logic [7:0]        ch;
    dc  = (d > CHAR_W'(DIGIT_MAX)) ? CHAR_W'(DIGIT_MAX) : d;
    pos = CHAR_W'(DIGIT_MAX) - dc;
    unique case (sel)
      ALPHA_RFC:     ch = RFC_DIGITS[8*pos +: 8];
      ALPHA_ASCII85: ch = 8'd33 + {1'b0, dc};
      default:       ch = Z85_DIGITS[8*pos +: 8];
    endcase
    return ch[CHAR_W-1:0];
  endfunction

endpackage

### src/base85_stream_encoder_unit.sv
// channel   | dir | handshake                  | payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata[7:0] data_byte, tlast stream_last
// m_axis    | out | m_axis_tvalid/tready       | tdata[6:0] out_char, tlast run_last,
//           |     |                            | tuser stream_done
// cfg       | in  | cfg_valid_i/cfg_ready_o    | cfg_data_i[1:0] alphabet_select
//
// One byte per request is taken while no group is being encoded. A closing
// byte starts the base-85 split: five digits through one x/85 reciprocal
// multiplier, each digit passing a multiply state and then a digit state, then
// one character per cycle while m_axis_tready is high.
// Reset is asynchronous, active low, and clears the partial group.
// Output stalls hold the block; no new byte is taken until the group drains.
module base85_stream_encoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic       m_axis_tlast,
  output logic       m_axis_tuser,   // [0] stream_done
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_data_i
);

  b85_pkg::cmd_t                  cmd;
  b85_pkg::status_t               status;
  logic [b85_pkg::CHAR_W-1:0]     out_char;

  assign cfg_ready_o = 1'b1;

  b85_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  b85_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (s_axis_tdata),
    .stream_last_i (s_axis_tlast),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_char_o    (out_char),
    .run_last_o    (m_axis_tlast),
    .stream_done_o (m_axis_tuser)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

### src/b85_ctrl.sv
module b85_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  b85_pkg::status_t status_i,
  output b85_pkg::cmd_t    cmd_o
);

  b85_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= b85_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      b85_pkg::ST_IDLE: begin
        if (in_valid_i && status_i.close) state_d = b85_pkg::ST_MUL;
      end
      b85_pkg::ST_MUL: state_d = b85_pkg::ST_DIG;
      b85_pkg::ST_DIG: begin
        state_d = status_i.dig_done ? b85_pkg::ST_EMIT : b85_pkg::ST_MUL;
      end
      b85_pkg::ST_EMIT: begin
        if (out_ready_i && status_i.emit_last) state_d = b85_pkg::ST_IDLE;
      end
      default: state_d = b85_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      b85_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
      end
      b85_pkg::ST_MUL:  cmd_o.mul = 1'b1;
      b85_pkg::ST_DIG:  cmd_o.dig = 1'b1;
      b85_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        cmd_o.pop   = out_ready_i;
      end
      default: ;
    endcase
  end

endmodule

### src/b85_dpath.sv
module b85_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [7:0]                   data_byte_i,
  input  logic                         stream_last_i,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_data_i,
  input  b85_pkg::cmd_t                cmd_i,
  output b85_pkg::status_t             status_o,
  output logic [b85_pkg::CHAR_W-1:0]   out_char_o,
  output logic                         run_last_o,
  output logic                         stream_done_o
);

  localparam int unsigned CW = b85_pkg::CHAR_W;
  localparam int unsigned IW = b85_pkg::IDX_W;
  localparam int unsigned QW = b85_pkg::QUOT_W;

  logic [1:0]         alpha_q;
  logic [31:0]        group_q, group_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [31:0]        x_q;
  logic [QW-1:0]      quot_q;
  logic [CW-1:0]      dig_q [b85_pkg::DIGITS];
  logic [IW-1:0]      nchar_q;
  logic               last_q;

  logic [31:0]        merged;
  logic [63:0]        prod;
  logic [CW-1:0]      q85;
  logic [CW-1:0]      digit;
  logic [IW-1:0]      stop_idx;
  logic               close;

  // big-endian placement of the new byte
  always_comb begin
    merged = group_q;
    case (cnt_q)
      2'd0:    merged[31:24] = data_byte_i;
      2'd1:    merged[23:16] = data_byte_i;
      2'd2:    merged[15:8]  = data_byte_i;
      default: merged[7:0]   = data_byte_i;
    endcase
  end

  assign close = (cnt_q == 2'd3) || stream_last_i;
  assign prod  = 64'(x_q) * 64'(b85_pkg::RECIP);

  // remainder is below 85, so the low 7 bits of x - 85*q are enough
  assign q85   = CW'(quot_q[CW-1:0] * CW'(85));
  assign digit = x_q[CW-1:0] - q85;

  assign stop_idx = IW'(b85_pkg::DIGITS) - nchar_q;

  always_comb begin
    group_d = group_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    if (cmd_i.take) begin
      if (close) begin
        group_d = '0;
        cnt_d   = '0;
        idx_d   = '0;
      end else begin
        group_d = merged;
        cnt_d   = cnt_q + 2'd1;
      end
    end
    if (cmd_i.dig && idx_q != IW'(b85_pkg::DIGITS - 1)) idx_d = idx_q + IW'(1);
    if (cmd_i.pop && !status_o.emit_last) idx_d = idx_q - IW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= b85_pkg::ALPHA_Z85;
      group_q <= '0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (cfg_we_i) alpha_q <= cfg_data_i;
      group_q <= group_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && close) begin
      x_q     <= merged;
      nchar_q <= IW'(cnt_q) + IW'(2);
      last_q  <= stream_last_i;
    end
    if (cmd_i.mul) quot_q <= prod[63:b85_pkg::RECIP_SHIFT];
    if (cmd_i.dig) begin
      dig_q[idx_q] <= digit;
      x_q          <= 32'(quot_q);
    end
  end

  assign status_o.close     = close;
  assign status_o.dig_done  = (idx_q == IW'(b85_pkg::DIGITS - 1));
  assign status_o.emit_last = (idx_q == stop_idx);

  // digits are stored by power of 85; output walks from the top power down
  assign out_char_o    = b85_pkg::digit_char(dig_q[idx_q], alpha_q);
  assign run_last_o    = status_o.emit_last;
  assign stream_done_o = status_o.emit_last && last_q;

endmodule

### src/b85_chk.sv
module b85_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast,
  input logic       m_axis_tuser,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [1:0] cfg_data_i
);

  // never takes a byte while a character is on offer
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while output valid");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("stream end without run end");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >= 8'd33) && (m_axis_tdata <= 8'd126))
    else $error("character outside printable range");

  // a final byte always closes a group and blocks input
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still ready after final byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
      $stable(m_axis_tuser))
    else $error("stalled output changed");

endmodule

bind base85_stream_encoder_unit b85_chk u_b85_chk (.*);
